// ===== src/lcs_pkg.sv =====
`default_nettype none

package lcs_pkg;

    localparam int DEF_MAX_LEN = 64;
    localparam int SYM_W       = 8;
    localparam int CNT_W       = 7;

    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SYM_W-1:0] symbol;
    } lcs_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic [CNT_W-1:0] lcs_length;
        logic             is_last;
        logic             is_empty;
    } lcs_out_t;

endpackage

`default_nettype wire

// ===== src/lcs_str_mem.sv =====
`default_nettype none

module lcs_str_mem #(
    parameter int IDX_W = 6
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_addr,
    input  wire logic [lcs_pkg::SYM_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output logic      [lcs_pkg::SYM_W-1:0] rd_data
);
    import lcs_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    logic [SYM_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/lcs_table_mem.sv =====
`default_nettype none

module lcs_table_mem #(
    parameter int ADDR_W = 12
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [lcs_pkg::CNT_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]         rd_a_addr,
    output logic      [lcs_pkg::CNT_W-1:0] rd_a_data,
    input  wire logic [ADDR_W-1:0]         rd_b_addr,
    output logic      [lcs_pkg::CNT_W-1:0] rd_b_data
);
    import lcs_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

// ===== src/lcs_engine.sv =====
`default_nettype none

module lcs_engine #(
    parameter int IDX_W   = 6,
    parameter int LEN_W   = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [LEN_W-1:0]           first_len,
    input  wire logic [LEN_W-1:0]           second_len,
    output logic      [IDX_W-1:0]           row_addr,
    output logic      [IDX_W-1:0]           col_addr,
    input  wire logic [lcs_pkg::SYM_W-1:0]  first_sym,
    input  wire logic [lcs_pkg::SYM_W-1:0]  second_sym,
    output logic                            tab_wr_en,
    output logic      [2*IDX_W-1:0]         tab_wr_addr,
    output logic      [lcs_pkg::CNT_W-1:0]  tab_wr_data,
    output logic      [2*IDX_W-1:0]         tab_a_addr,
    input  wire logic [lcs_pkg::CNT_W-1:0]  tab_a_data,
    output logic      [2*IDX_W-1:0]         tab_b_addr,
    input  wire logic [lcs_pkg::CNT_W-1:0]  tab_b_data,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output lcs_pkg::lcs_out_t               result_item
);
    import lcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_RD,
        S_FILL_WR,
        S_TOT_RD,
        S_TOT_EV,
        S_WALK_RD,
        S_WALK_EV,
        S_EMPTY
    } state_t;

    state_t           state_reg,     state_next;
    logic [LEN_W-1:0] row_reg,       row_next;
    logic [LEN_W-1:0] col_reg,       col_next;
    logic [CNT_W-1:0] left_reg,      left_next;
    logic [CNT_W-1:0] diag_reg,      diag_next;
    logic [CNT_W-1:0] total_reg,     total_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             out_valid_reg, out_valid_next;
    lcs_out_t         out_item_reg,  out_item_next;

    logic [LEN_W-1:0] row_inc;
    logic [LEN_W-1:0] col_inc;
    logic [CNT_W-1:0] below;
    logic [CNT_W-1:0] right;
    logic [CNT_W-1:0] fill_val;
    logic [CNT_W-1:0] cnt_inc;
    logic             sym_match;
    logic             slot_free;

    assign row_inc   = row_reg + LEN_W'(1);
    assign col_inc   = col_reg + LEN_W'(1);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign sym_match = (first_sym == second_sym);
    assign slot_free = !out_valid_reg || !result_stall;

    // border cells read as zero
    assign below = (row_inc >= first_len)  ? '0 : tab_a_data;
    assign right = (col_inc >= second_len) ? '0 : tab_b_data;

    always_comb
    begin
        if (sym_match)
        begin
            fill_val = diag_reg + CNT_W'(1);
        end
        else
        begin
            fill_val = (left_reg > below) ? left_reg : below;
        end
    end

    assign row_addr    = row_reg[IDX_W-1:0];
    assign col_addr    = col_reg[IDX_W-1:0];
    assign tab_wr_en   = (state_reg == S_FILL_WR);
    assign tab_wr_addr = {row_reg[IDX_W-1:0], col_reg[IDX_W-1:0]};
    assign tab_wr_data = fill_val;
    assign tab_a_addr  = (state_reg == S_TOT_RD) ? '0
                       : {row_inc[IDX_W-1:0], col_reg[IDX_W-1:0]};
    assign tab_b_addr  = {row_reg[IDX_W-1:0], col_inc[IDX_W-1:0]};

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (first_len == '0 || second_len == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        row_next   = first_len - LEN_W'(1);
                        col_next   = second_len - LEN_W'(1);
                        left_next  = '0;
                        diag_next  = '0;
                        state_next = S_FILL_RD;
                    end
                end
            end
            S_FILL_RD:
            begin
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                left_next = fill_val;
                diag_next = below;
                if (col_reg == '0)
                begin
                    if (row_reg == '0)
                    begin
                        state_next = S_TOT_RD;
                    end
                    else
                    begin
                        row_next   = row_reg - LEN_W'(1);
                        col_next   = second_len - LEN_W'(1);
                        left_next  = '0;
                        diag_next  = '0;
                        state_next = S_FILL_RD;
                    end
                end
                else
                begin
                    col_next   = col_reg - LEN_W'(1);
                    state_next = S_FILL_RD;
                end
            end
            S_TOT_RD:
            begin
                state_next = S_TOT_EV;
            end
            S_TOT_EV:
            begin
                total_next = tab_a_data;
                row_next   = '0;
                col_next   = '0;
                cnt_next   = '0;
                state_next = (tab_a_data == '0) ? S_EMPTY : S_WALK_RD;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_EV;
            end
            S_WALK_EV:
            begin
                if (sym_match)
                begin
                    if (slot_free)
                    begin
                        out_valid_next           = 1'b1;
                        out_item_next.out_symbol = first_sym;
                        out_item_next.lcs_length = total_reg;
                        out_item_next.is_last    = (cnt_inc == total_reg);
                        out_item_next.is_empty   = 1'b0;
                        cnt_next                 = cnt_inc;
                        row_next                 = row_inc;
                        col_next                 = col_inc;
                        state_next = (cnt_inc == total_reg) ? S_IDLE : S_WALK_RD;
                    end
                end
                else
                begin
                    if (below > right)
                    begin
                        row_next = row_inc;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    state_next = S_WALK_RD;
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.out_symbol = '0;
                    out_item_next.lcs_length = '0;
                    out_item_next.is_last    = 1'b1;
                    out_item_next.is_empty   = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ===== src/lcs_length_and_trace.sv =====
`default_nettype none

// Longest common subsequence of two byte strings. Load items (cmd 0 or 1) append
// one symbol to the first or second string, up to MAX_LEN each; extra symbols
// are dropped. A compute item (cmd 2) fills a suffix table of lengths in a
// dual-read table memory, one cell per read state and write state, reads back
// the total in a read state and an evaluate state, then walks the table from
// the start, one read and one evaluate state per step (at most n1+n2 steps),
// emitting one result item per common symbol with its length and a last mark;
// with no common symbol a single item flagged empty comes out. An output stall
// holds the walk at a matching step. cmd_stall stays high from the compute item
// until its final result sits in the output register. The strings are kept
// across computes; later loads append to them. cmd 3 is accepted and ignored.
module lcs_length_and_trace #(
    parameter int MAX_LEN = lcs_pkg::DEF_MAX_LEN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire lcs_pkg::lcs_in_t  cmd_item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output lcs_pkg::lcs_out_t      result_item
);
    import lcs_pkg::*;

    // index width for one string, length counter width holds MAX_LEN itself
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [LEN_W-1:0]   first_len_reg,  first_len_next;
    logic [LEN_W-1:0]   second_len_reg, second_len_next;

    logic               accept;
    logic               first_wr;
    logic               second_wr;
    logic               start;
    logic               busy;
    logic [IDX_W-1:0]   row_addr;
    logic [IDX_W-1:0]   col_addr;
    logic [SYM_W-1:0]   first_sym;
    logic [SYM_W-1:0]   second_sym;
    logic               tab_wr_en;
    logic [2*IDX_W-1:0] tab_wr_addr;
    logic [CNT_W-1:0]   tab_wr_data;
    logic [2*IDX_W-1:0] tab_a_addr;
    logic [CNT_W-1:0]   tab_a_data;
    logic [2*IDX_W-1:0] tab_b_addr;
    logic [CNT_W-1:0]   tab_b_data;

    // one item at a time: nothing is taken while a compute runs
    assign cmd_stall = busy;
    assign accept    = cmd_valid && !cmd_stall;

    // loads into a full string are dropped
    assign first_wr  = accept && (cmd_item.cmd == CMD_LOAD_FIRST)
                     && (first_len_reg < LEN_W'(MAX_LEN));
    assign second_wr = accept && (cmd_item.cmd == CMD_LOAD_SECOND)
                     && (second_len_reg < LEN_W'(MAX_LEN));
    assign start     = accept && (cmd_item.cmd == CMD_COMPUTE);

    assign first_len_next  = first_wr  ? first_len_reg + LEN_W'(1)  : first_len_reg;
    assign second_len_next = second_wr ? second_len_reg + LEN_W'(1) : second_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
        end
    end

    // string stores: written at the fill count, read at the engine's row / column
    lcs_str_mem #(
        .IDX_W (IDX_W)
    ) u_first_mem (
        .clk     (clk),
        .wr_en   (first_wr),
        .wr_addr (first_len_reg[IDX_W-1:0]),
        .wr_data (cmd_item.symbol),
        .rd_addr (row_addr),
        .rd_data (first_sym)
    );

    lcs_str_mem #(
        .IDX_W (IDX_W)
    ) u_second_mem (
        .clk     (clk),
        .wr_en   (second_wr),
        .wr_addr (second_len_reg[IDX_W-1:0]),
        .wr_data (cmd_item.symbol),
        .rd_addr (col_addr),
        .rd_data (second_sym)
    );

    // suffix table, addressed as {row, col}
    lcs_table_mem #(
        .ADDR_W (2 * IDX_W)
    ) u_table_mem (
        .clk       (clk),
        .wr_en     (tab_wr_en),
        .wr_addr   (tab_wr_addr),
        .wr_data   (tab_wr_data),
        .rd_a_addr (tab_a_addr),
        .rd_a_data (tab_a_data),
        .rd_b_addr (tab_b_addr),
        .rd_b_data (tab_b_data)
    );

    // fill, walk and output register
    lcs_engine #(
        .IDX_W   (IDX_W),
        .LEN_W   (LEN_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_len    (first_len_reg),
        .second_len   (second_len_reg),
        .row_addr     (row_addr),
        .col_addr     (col_addr),
        .first_sym    (first_sym),
        .second_sym   (second_sym),
        .tab_wr_en    (tab_wr_en),
        .tab_wr_addr  (tab_wr_addr),
        .tab_wr_data  (tab_wr_data),
        .tab_a_addr   (tab_a_addr),
        .tab_a_data   (tab_a_data),
        .tab_b_addr   (tab_b_addr),
        .tab_b_data   (tab_b_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire
